@@ hw/rtl/sic_pkg.sv @@
// Shared constants, types and codes for the segmented index codec.
`timescale 1ns / 1ps

package sic_pkg;

   // Table geometry. The segment size is 2**SEG_BITS (SEG_BITS from 1 to 16).
   localparam int TABLE_DEPTH = 256;
   localparam int SEG_BITS    = 16;
   localparam int INDEX_WIDTH = 24;

   // Fixed field widths of the stream words.
   localparam int POS_W       = 24;
   localparam int SHORT_W     = 16;
   localparam int REQ_DATA_W  = 64;
   localparam int RSP_DATA_W  = 40;

   // Derived widths.
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int CMP_W = POS_W + CNT_W;

   localparam logic [POS_W-1:0] FULL_MASK = (INDEX_WIDTH >= POS_W) ? {POS_W{1'b1}} :
                                            POS_W'((64'd1 << INDEX_WIDTH) - 64'd1);
   localparam logic [POS_W-1:0] SEG_MASK  = POS_W'((64'd1 << SEG_BITS) - 64'd1);

   // Item kinds carried in the request tuser bit.
   localparam logic ACT_ENCODE = 1'b0;
   localparam logic ACT_DECODE = 1'b1;

   // Control broadcast from the sequencer to every boundary cell.
   typedef struct packed {
      logic             shift;
      logic [POS_W-1:0] pos;
   } cell_ctl_type;

endpackage

@@ hw/rtl/sic_cell.sv @@
// One boundary cell: holds one table entry and compares it with the query position.
`timescale 1ns / 1ps

module sic_cell import sic_pkg::*; (
   input  logic             clock,
   input  cell_ctl_type     ctl,
   input  logic [POS_W-1:0] prev_entry,
   output logic [POS_W-1:0] entry,
   output logic             gt
);

   logic [POS_W-1:0] entry_ff, entry_in;
   logic             gt_ff, gt_in;

   // On an append every cell takes its neighbor's entry, so the newest entry sits in cell 0.
   always_comb begin
      entry_in = ctl.shift ? prev_entry : entry_ff;
      gt_in    = (entry_ff > ctl.pos);
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      gt_ff    <= gt_in;
   end

   assign entry = entry_ff;
   assign gt    = gt_ff;

endmodule

@@ hw/rtl/sic_chain.sv @@
// Row of boundary cells that shifts on append and yields one compare bit per cell.
`timescale 1ns / 1ps

module sic_chain import sic_pkg::*; (
   input  logic                   clock,
   input  cell_ctl_type           ctl,
   output logic [TABLE_DEPTH-1:0] gt_vec
);

   logic [POS_W-1:0] links [TABLE_DEPTH+1];

   assign links[0] = ctl.pos;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      sic_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .prev_entry (links[i]),
         .entry      (links[i+1]),
         .gt         (gt_vec[i])
      );
   end

endmodule

@@ hw/rtl/segmented_index_codec_core.sv @@
// Top level of the segmented index codec: sequencer, search unit and stream ports.
// Encode words need no search: execution passes straight on to the result.
// Decode words may run a binary search over the table, which probes one cell compare
// bit per cycle; a new word is accepted only once the last result is registered.
// Reset (synchronous, active high) empties the table and drops any pending result.
`timescale 1ns / 1ps

module segmented_index_codec_core import sic_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,

   // Request stream.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // tdata: full index[23:0], list position[47:24], short index[63:48]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // tuser: action (0 encode, 1 decode)
   input  logic                  req_tuser,

   // Result stream.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // tdata: short index result[15:0], full index result[39:16]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // tuser: table_full
   output logic                  rsp_tuser
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SETUP,
      ST_SEARCH,
      ST_FINISH
   } state_type;

   // The table lives in the cell chain; cell 0 holds the newest entry, so the
   // logical entry k sits in cell (count - 1 - k).

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    action_ff, action_in;
   logic [POS_W-1:0]        full_ff, full_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [SHORT_W-1:0]      sidx_ff, sidx_in;
   logic [IDX_W-1:0]        lo_ff, lo_in;
   logic [IDX_W-1:0]        hi_ff, hi_in;
   logic [IDX_W-1:0]        last_ff, last_in;
   logic [SHORT_W-1:0]      res_short_ff, res_short_in;
   logic [POS_W-1:0]        res_full_ff, res_full_in;
   logic                    res_flag_ff, res_flag_in;
   logic                    rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                    rsp_user_ff, rsp_user_in;

   logic                    accept;
   logic                    need_append;
   logic                    has_room;
   logic [IDX_W:0]          mid_sum;
   logic [IDX_W-1:0]        mid;
   logic [IDX_W-1:0]        probe_cell;
   logic                    span_open;
   cell_ctl_type            cell_ctl;
   logic [TABLE_DEPTH-1:0]  gt_vec;

   // Segment number times segment size plus the short index, wrapped to the index width.
   function automatic logic [POS_W-1:0] dec_value(input logic [IDX_W-1:0]   seg,
                                                 input logic [SHORT_W-1:0] sidx);
      logic [CMP_W-1:0] sum;
      sum = (CMP_W'(seg) << SEG_BITS) + CMP_W'(sidx);
      return POS_W'(sum) & FULL_MASK;
   endfunction

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // An append is due when the table is empty or the index has reached count segments.
   assign need_append = (count_ff == '0) ||
                        (CMP_W'(full_ff) >= (CMP_W'(count_ff) << SEG_BITS));
   assign has_room    = (count_ff < CNT_W'(TABLE_DEPTH));

   // Search probe: the midpoint, mapped from logical entry to physical cell.
   assign mid_sum    = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid        = mid_sum[IDX_W:1];
   assign probe_cell = last_ff - mid;
   assign span_open  = ((hi_ff - lo_ff) > IDX_W'(1));

   assign cell_ctl.shift = (state_ff == ST_EXEC) && (action_ff == ACT_ENCODE) &&
                           need_append && has_room;
   assign cell_ctl.pos   = pos_ff;

   sic_chain u_chain (
      .clock  (clock),
      .ctl    (cell_ctl),
      .gt_vec (gt_vec)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      action_in     = action_ff;
      full_in       = full_ff;
      pos_in        = pos_ff;
      sidx_in       = sidx_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      last_in       = last_ff;
      res_short_in  = res_short_ff;
      res_full_in   = res_full_ff;
      res_flag_in   = res_flag_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               action_in = req_tuser;
               full_in   = req_tdata[POS_W-1:0] & FULL_MASK;
               pos_in    = req_tdata[2*POS_W-1:POS_W];
               sidx_in   = req_tdata[2*POS_W+SHORT_W-1:2*POS_W];
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (action_ff == ACT_ENCODE) begin
               res_short_in = SHORT_W'(full_ff & SEG_MASK);
               res_full_in  = '0;
               res_flag_in  = need_append && !has_room;
               if (need_append && has_room) begin
                  count_in = count_ff + CNT_W'(1);
               end
               state_in = ST_FINISH;
            end else begin
               res_short_in = '0;
               res_flag_in  = 1'b0;
               if (count_ff == '0) begin
                  res_full_in = dec_value('0, sidx_ff);
                  state_in    = ST_FINISH;
               end else begin
                  // The cells register their compare bits during this cycle.
                  last_in  = IDX_W'(count_ff - CNT_W'(1));
                  state_in = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            // Cell 0 holds the last entry; at or above it, the last segment wins.
            if (!gt_vec[0]) begin
               res_full_in = dec_value(last_ff, sidx_ff);
               state_in    = ST_FINISH;
            end else begin
               lo_in    = '0;
               hi_in    = last_ff;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (span_open) begin
               if (gt_vec[probe_cell]) begin
                  hi_in = mid;
               end else begin
                  lo_in = mid;
               end
            end else begin
               res_full_in = dec_value(lo_ff, sidx_ff);
               state_in    = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_data_in   = {res_full_ff, res_short_ff};
               rsp_user_in   = res_flag_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      action_ff    <= action_in;
      full_ff      <= full_in;
      pos_ff       <= pos_in;
      sidx_ff      <= sidx_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      last_ff      <= last_in;
      res_short_ff <= res_short_in;
      res_full_ff  <= res_full_in;
      res_flag_ff  <= res_flag_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // The table never holds more entries than it has cells.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("boundary count exceeds table depth");

   // At most one entry is appended per cycle.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (count_ff == $past(count_ff)) || (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("boundary count changed by more than one");

   // The search window never inverts.
   a_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> (hi_ff >= lo_ff))
      else $error("search window inverted");

   // An accepted word always leaves the idle state.
   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_EXEC))
      else $error("accepted word not taken into execution");

   // The count only grows on an encode word in execution.
   a_append_only_encode: assert property (@(posedge clock) disable iff (reset)
      (count_in != count_ff) |-> ((state_ff == ST_EXEC) && (action_ff == ACT_ENCODE)))
      else $error("boundary appended outside an encode word");

endmodule
